>>> design/dre_pkg.sv
// ----------------------------------------------------------------------------
// DNS resolver entry engine package
// Shared types and codes for the slot table and the response parser.
// ----------------------------------------------------------------------------
package dre_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_BYTE  = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_ALLOC   = 3'd0,
      KIND_SEND    = 3'd1,
      KIND_FAILED  = 3'd2,
      KIND_ADDR    = 3'd3,
      KIND_NOADDR  = 3'd4,
      KIND_IGNORED = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_UNUSED = 3'd0,
      ST_NEW    = 3'd1,
      ST_ASKING = 3'd2,
      ST_DONE   = 3'd3,
      ST_ERROR  = 3'd4
   } slot_state_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [4:0] slot;
      logic [31:0] ip_address;
      logic [3:0] server_error;
   } result_type;

   localparam logic [7:0] RETRY_RESET = 8'd8;

   // most results one tick may produce
   localparam logic [2:0] TICK_MAX_RESULTS = 3'd5;

endpackage

>>> design/dre_parser.sv
// ----------------------------------------------------------------------------
// DNS response parser
// Walks one response byte per call: header, question, answer records.
// Reports the matched slot ID and at most one result per packet.
// ----------------------------------------------------------------------------
module dre_parser
   import dre_pkg::*;
#(
   parameter int SLOTS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_en,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   input  slot_state_type    id_state,     // state of the slot named by the ID
   output logic [15:0]       id_value,
   output logic              id_done_we,   // set matched slot done
   output logic              id_err_we,    // set matched slot error
   output result_type        result
);

   typedef enum logic [3:0] {
      PH_HEADER, PH_QLEN, PH_QSKIP, PH_QPTR, PH_QTAIL, PH_ALEN,
      PH_ASKIP, PH_APTR, PH_AFIXED, PH_ADATA, PH_AIP, PH_DRAIN
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] skip_ff, skip_in;
   logic [7:0]  left_ff, left_in;
   logic        match_ff, match_in;
   logic [4:0]  mslot_ff, mslot_in;
   logic [63:0] fields_ff, fields_in;

   logic [15:0] skip_dec;
   logic        skip_zero;
   logic [3:0]  k;
   logic [15:0] typ, cls, len;
   logic [63:0] af;

   assign id_value = fields_ff[15:0];
   assign skip_dec = (skip_ff != 16'd0) ? skip_ff - 16'd1 : 16'd0;
   assign skip_zero = (skip_dec == 16'd0);
   assign k = 4'd10 - ((skip_ff > 16'd10) ? 4'd10 : skip_ff[3:0]);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      skip_in   = skip_ff;
      left_in   = left_ff;
      match_in  = match_ff;
      mslot_in  = mslot_ff;
      fields_in = fields_ff;
      id_done_we = 1'b0;
      id_err_we  = 1'b0;
      result = '0;
      af = fields_ff;
      typ = '0; cls = '0; len = '0;
      if (byte_en) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == 16'd0) begin
                  fields_in = {48'd0, data_byte, 8'd0};
               end else if (pos_ff == 16'd1) begin
                  fields_in = fields_ff | {56'd0, data_byte};
               end else if (pos_ff == 16'd3) begin
                  if (fields_ff[15:0] < 16'(SLOTS) && id_state == ST_ASKING) begin
                     match_in = 1'b1;
                     mslot_in = fields_ff[4:0];
                     if (data_byte[3:0] != 4'd0) begin
                        id_err_we = 1'b1;
                        result = '{1'b1, KIND_FAILED, fields_ff[4:0], 32'd0,
                                   data_byte[3:0]};
                        phase_in = PH_DRAIN;
                     end else begin
                        id_done_we = 1'b1;
                     end
                  end else begin
                     result = '{1'b1, KIND_IGNORED, 5'd0, 32'd0, 4'd0};
                     phase_in = PH_DRAIN;
                  end
               end else if (pos_ff == 16'd6) begin
                  fields_in = fields_ff | {32'd0, data_byte, 24'd0};
               end else if (pos_ff == 16'd7) begin
                  left_in = (fields_ff[31:24] != 8'd0) ? 8'd255 : data_byte;
               end else if (pos_ff == 16'd11) begin
                  phase_in = PH_QLEN;
               end
               if (pos_ff != 16'hffff) pos_in = pos_ff + 16'd1;
            end
            PH_QLEN, PH_ALEN: begin
               if ((data_byte & 8'hc0) != 8'd0) begin
                  phase_in = (phase_ff == PH_ALEN) ? PH_APTR : PH_QPTR;
               end else if (data_byte == 8'd0) begin
                  if (phase_ff == PH_ALEN) begin
                     phase_in = PH_AFIXED; skip_in = 16'd10; fields_in = '0;
                  end else begin
                     phase_in = PH_QTAIL; skip_in = 16'd4;
                  end
               end else begin
                  skip_in = {8'd0, data_byte};
                  phase_in = (phase_ff == PH_ALEN) ? PH_ASKIP : PH_QSKIP;
               end
            end
            PH_QSKIP: begin
               skip_in = skip_dec;
               if (skip_zero) phase_in = PH_QLEN;
            end
            PH_ASKIP: begin
               skip_in = skip_dec;
               if (skip_zero) phase_in = PH_ALEN;
            end
            PH_QPTR: begin
               phase_in = PH_QTAIL; skip_in = 16'd4;
            end
            PH_APTR: begin
               phase_in = PH_AFIXED; skip_in = 16'd10; fields_in = '0;
            end
            PH_QTAIL: begin
               skip_in = skip_dec;
               if (skip_zero) begin
                  if (left_ff == 8'd0) begin
                     result = '{1'b1, KIND_NOADDR, mslot_ff, 32'd0, 4'd0};
                     phase_in = PH_DRAIN;
                  end else begin
                     phase_in = PH_ALEN;
                  end
               end
            end
            PH_AFIXED: begin
               if (k < 4'd4)
                  af = fields_ff | ({56'd0, data_byte} << (6'd8 * (6'd7 - 6'(k))));
               else if (k == 4'd8)
                  af = fields_ff | {48'd0, data_byte, 8'd0};
               else if (k == 4'd9)
                  af = fields_ff | {56'd0, data_byte};
               fields_in = af;
               skip_in = skip_dec;
               typ = af[63:48]; cls = af[47:32]; len = af[15:0];
               if (skip_zero) begin
                  if (typ == 16'd1 && cls == 16'd1 && len == 16'd4) begin
                     phase_in = PH_AIP; skip_in = 16'd4; fields_in = '0;
                  end else if (len == 16'd0) begin
                     left_in = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;
                     if (left_in == 8'd0) begin
                        result = '{1'b1, KIND_NOADDR, mslot_ff, 32'd0, 4'd0};
                        phase_in = PH_DRAIN;
                     end else phase_in = PH_ALEN;
                  end else begin
                     phase_in = PH_ADATA; skip_in = len;
                  end
               end
            end
            PH_ADATA: begin
               skip_in = skip_dec;
               if (skip_zero) begin
                  left_in = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;
                  if (left_in == 8'd0) begin
                     result = '{1'b1, KIND_NOADDR, mslot_ff, 32'd0, 4'd0};
                     phase_in = PH_DRAIN;
                  end else phase_in = PH_ALEN;
               end
            end
            PH_AIP: begin
               fields_in = {32'd0, fields_ff[23:0], data_byte};
               skip_in = skip_dec;
               if (skip_zero) begin
                  result = '{1'b1, KIND_ADDR, mslot_ff, fields_in[31:0], 4'd0};
                  phase_in = PH_DRAIN;
               end
            end
            default: ;
         endcase
         if (last_byte) begin
            if (phase_in != PH_DRAIN && !result.valid) begin
               if (match_in)
                  result = '{1'b1, KIND_NOADDR, mslot_in, 32'd0, 4'd0};
               else
                  result = '{1'b1, KIND_IGNORED, 5'd0, 32'd0, 4'd0};
            end
            phase_in = PH_HEADER; pos_in = '0; skip_in = '0; left_in = '0;
            match_in = 1'b0; fields_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= '0;
         skip_ff   <= '0;
         left_ff   <= '0;
         match_ff  <= 1'b0;
         mslot_ff  <= '0;
         fields_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         skip_ff   <= skip_in;
         left_ff   <= left_in;
         match_ff  <= match_in;
         mslot_ff  <= mslot_in;
         fields_ff <= fields_in;
      end
   end

endmodule

>>> design/dns_resolver_entry_engine.sv
// ----------------------------------------------------------------------------
// DNS resolver entry engine
// Slot table with tick-driven retry timers and a streaming response parser.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one transaction per item: tdata = {last_byte, data_byte, func},
//   func at bit 0. rsp_ returns result transactions, tlast set on the final
//   result of one input. The user writes retry_limit (reset 8) over csr_ only
//   while idle; the block does not enforce this. A response byte that yields
//   a result hands it off before the next byte is taken.
//   A query request walks the slot table with one shared compare / decrement
//   unit, one slot per cycle, then allocates the picked slot in S_QSET
//   before its result goes. A tick walks the same way, pausing while a
//   result waits in S_OUT; a failed slot is held until the walk finds the
//   next result or ends, so tlast lands on the final one. A tick gives at
//   most five results.
//   Results are held in a one-entry output register; req_tready stays low
//   while work runs or a result waits, so a stalled receiver backs the
//   whole block up without loss. Synchronous reset empties the slot table,
//   puts the parser in its header phase and drops any pending result.
// ----------------------------------------------------------------------------
module dns_resolver_entry_engine
   import dre_pkg::*;
#(
   parameter int SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // func[1:0], data_byte[9:2], last_byte[10]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // kind[2:0], slot[7:3], ip[39:8], err[43:40]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [2:0] {S_IDLE, S_TICK, S_QUERY, S_QSET, S_OUT} fsm_type;

   fsm_type        st_ff;
   slot_state_type sst_ff [SLOTS];
   logic [7:0]     tmr_ff [SLOTS];
   logic [7:0]     rty_ff [SLOTS];
   logic [7:0]     age_ff [SLOTS];
   logic [7:0]     next_age_ff;
   logic [7:0]     limit_ff;
   logic [IW:0]    idx_ff;       // walk counter, holds SLOTS at the end
   logic [IW-1:0]  pick_ff;
   logic [7:0]     oldest_ff;
   logic           found_ff;
   result_type     res_ff;
   logic           res_last_ff;
   logic           walk_last_ff; // walk done after current result
   logic           pend_ff;      // failure held in res_ff during a tick
   logic [2:0]     cnt_ff;       // failures produced by the current tick

   logic [IW-1:0]  ci;
   logic [7:0]     tdec, rinc, dage;
   logic           ev_hit;
   logic           req_acc;
   func_type       func;
   logic           byte_en;
   logic [15:0]    id_value;
   logic           id_done_we, id_err_we;
   result_type     presult;
   slot_state_type id_state;
   logic [IW-1:0]  id_idx;

   assign func    = func_type'(req_tdata[1:0]);
   assign req_acc = req_tvalid && req_tready;
   assign byte_en = req_acc && func == FUNC_BYTE;
   assign req_tready = (st_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign ci   = idx_ff[IW-1:0];
   assign tdec = tmr_ff[ci] - 8'd1;
   assign rinc = rty_ff[ci] + 8'd1;
   assign dage = next_age_ff - age_ff[ci];
   assign ev_hit = (sst_ff[ci] == ST_ASKING && tdec == 8'd0) || sst_ff[ci] == ST_NEW;
   assign id_idx   = id_value[IW-1:0];
   assign id_state = (id_value < 16'(SLOTS)) ? sst_ff[id_idx] : ST_UNUSED;

   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tlast  = res_last_ff;
   assign rsp_tdata  = {4'd0, res_ff.server_error, res_ff.ip_address, res_ff.slot,
                        res_ff.kind};

   dre_parser #(.SLOTS(SLOTS)) u_parser (
      .clock, .reset, .byte_en,
      .data_byte (req_tdata[9:2]),
      .last_byte (req_tdata[10]),
      .id_state, .id_value, .id_done_we, .id_err_we,
      .result    (presult)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         next_age_ff  <= '0;
         limit_ff     <= RETRY_RESET;
         idx_ff       <= '0;
         pick_ff      <= '0;
         oldest_ff    <= '0;
         found_ff     <= 1'b0;
         res_last_ff  <= 1'b0;
         walk_last_ff <= 1'b0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         res_ff       <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            sst_ff[i] <= ST_UNUSED;
            tmr_ff[i] <= '0;
            rty_ff[i] <= '0;
            age_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) limit_ff <= csr_wdata;
         unique case (st_ff)
            S_IDLE: begin
               idx_ff <= '0;
               oldest_ff <= '0;
               pick_ff <= '0;
               found_ff <= 1'b0;
               pend_ff <= 1'b0;
               cnt_ff <= '0;
               if (req_acc) begin
                  unique case (func)
                     FUNC_TICK:  st_ff <= S_TICK;
                     FUNC_QUERY: st_ff <= S_QUERY;
                     FUNC_BYTE: begin
                        if (id_err_we) sst_ff[id_idx] <= ST_ERROR;
                        if (id_done_we) sst_ff[id_idx] <= ST_DONE;
                        if (presult.valid) begin
                           res_ff <= presult;
                           res_last_ff <= 1'b1;
                           walk_last_ff <= 1'b1;
                           st_ff <= S_OUT;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            // one slot per cycle unless a held failure is released; stop at a send, at the result cap or at the end
            S_TICK: begin
               if (idx_ff == (IW+1)'(SLOTS)) begin
                  // release a held failure as the final result of this tick
                  if (pend_ff) begin
                     pend_ff      <= 1'b0;
                     walk_last_ff <= 1'b1;
                     res_last_ff  <= 1'b1;
                     st_ff        <= S_OUT;
                  end else begin
                     st_ff <= S_IDLE;
                  end
               end else if (pend_ff && ev_hit) begin
                  // another result follows: release the held one, revisit this slot
                  pend_ff      <= 1'b0;
                  walk_last_ff <= 1'b0;
                  res_last_ff  <= 1'b0;
                  st_ff        <= S_OUT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  if (sst_ff[ci] == ST_ASKING) begin
                     tmr_ff[ci] <= tdec;
                     if (tdec == 8'd0) begin
                        rty_ff[ci] <= rinc;
                        if (rinc == limit_ff) begin
                           sst_ff[ci] <= ST_ERROR;
                           res_ff <= '{1'b1, KIND_FAILED, 5'(ci), 32'd0, 4'd0};
                           cnt_ff <= cnt_ff + 3'd1;
                           if (cnt_ff == TICK_MAX_RESULTS - 3'd1) begin
                              walk_last_ff <= 1'b1;
                              res_last_ff  <= 1'b1;
                              st_ff        <= S_OUT;
                           end else begin
                              pend_ff <= 1'b1;
                           end
                        end else begin
                           tmr_ff[ci] <= rinc;
                           res_ff <= '{1'b1, KIND_SEND, 5'(ci), 32'd0, 4'd0};
                           walk_last_ff <= 1'b1;
                           res_last_ff  <= 1'b1;
                           st_ff        <= S_OUT;
                        end
                     end
                  end else if (sst_ff[ci] == ST_NEW) begin
                     sst_ff[ci] <= ST_ASKING;
                     tmr_ff[ci] <= 8'd1;
                     rty_ff[ci] <= 8'd0;
                     res_ff <= '{1'b1, KIND_SEND, 5'(ci), 32'd0, 4'd0};
                     walk_last_ff <= 1'b1;
                     res_last_ff  <= 1'b1;
                     st_ff <= S_OUT;
                  end
               end
            end
            // search: first unused, else oldest tag
            S_QUERY: begin
               if (idx_ff == (IW+1)'(SLOTS)) begin
                  st_ff <= S_QSET;
               end else if (sst_ff[ci] == ST_UNUSED) begin
                  pick_ff <= ci;
                  st_ff <= S_QSET;
               end else begin
                  if (dage > oldest_ff) begin
                     oldest_ff <= dage;
                     pick_ff <= ci;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_QSET: begin
               sst_ff[pick_ff] <= ST_NEW;
               age_ff[pick_ff] <= next_age_ff;
               next_age_ff <= next_age_ff + 8'd1;
               res_ff <= '{1'b1, KIND_ALLOC, 5'(pick_ff), 32'd0, 4'd0};
               res_last_ff  <= 1'b1;
               walk_last_ff <= 1'b1;
               st_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  // resume the tick walk unless this was its final result
                  st_ff <= walk_last_ff ? S_IDLE : S_TICK;
                  walk_last_ff <= 1'b0;
                  res_last_ff  <= 1'b0;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

endmodule
